@@ rtl/alle_pkg.sv @@
// Shared codes and fixed field widths for the array linked list engine.
// No dependencies; every other file but alle_ram uses this package.
`default_nettype none

package alle_pkg;

  localparam int OP_W  = 3;
  localparam int POS_W = 8;
  localparam int ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND    = 3'd0,
    OP_INSERT    = 3'd1,
    OP_READ      = 3'd2,
    OP_OVERWRITE = 3'd3,
    OP_REMOVE    = 3'd4,
    OP_SEARCH    = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_POP    = 10'b0000000100,
    S_WALK   = 10'b0000001000,
    S_SCAN   = 10'b0000010000,
    S_ACCESS = 10'b0000100000,
    S_LINK   = 10'b0001000000,
    S_LINK2  = 10'b0010000000,
    S_FREE   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

endpackage

`default_nettype wire

@@ rtl/alle_if.sv @@
// Request and response channel interfaces of the array linked list engine.
// Depends on alle_pkg for the fixed field widths.
`default_nettype none

interface alle_req_if #(
  parameter int VALUE_WIDTH = 32
) ();
  logic                              valid;
  logic                              ready;
  logic [alle_pkg::OP_W-1:0]         op;
  logic [alle_pkg::POS_W-1:0]        position;
  logic signed [VALUE_WIDTH-1:0]     value;

  modport source (output valid, op, position, value, input ready);
  modport sink   (input valid, op, position, value, output ready);
endinterface

interface alle_rsp_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 9
) ();
  logic                              valid;
  logic                              ready;
  logic signed [VALUE_WIDTH-1:0]     read_value;
  logic [alle_pkg::POS_W-1:0]        found_position;
  logic [alle_pkg::ST_W-1:0]         status;
  logic [COUNT_WIDTH-1:0]            item_count;

  modport source (output valid, read_value, found_position, status, item_count, input ready);
  modport sink   (input valid, read_value, found_position, status, item_count, output ready);
endinterface

`default_nettype wire

@@ rtl/array_linked_list_engine.sv @@
// Array linked list engine: positional list kept as a linked chain in RAM.
// Depends on alle_pkg, alle_if (alle_req_if, alle_rsp_if) and alle_ram.
//
// Usage:
//   req carries one operation per transaction (op, position, value); rsp
//   returns exactly one transaction per request (read_value, found_position,
//   status, item_count). Requests are taken one at a time: req.ready is high
//   only while the sequencer is idle.
// Every positional walk and every search steps the link RAM read port
// once per cycle.
// Reset empties the list at once: slots never used are handed out by a fill
// counter, so no clearing pass runs and no slot carries a valid bit.
// When the receiver stalls, the finished response holds in the output
// register; the next request is still accepted and its result waits in the
// sequencer until the output register frees.

`default_nettype none

module array_linked_list_engine #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  alle_req_if.sink  req,
  alle_rsp_if.source rsp
);

  import alle_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int LINK_W = $clog2(CAPACITY + 1);
  localparam int CNT_W  = LINK_W;
  localparam int PW     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);
  localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);

  state_t state;

  // list bookkeeping
  logic [LINK_W-1:0] head;
  logic [LINK_W-1:0] tail;
  logic [LINK_W-1:0] free_head;
  logic [LINK_W-1:0] fresh;
  logic [CNT_W-1:0]  count;

  // current request
  logic [OP_W-1:0]        op_r;
  logic [POS_W-1:0]       pos_raw;
  logic [CNT_W-1:0]       pos_r;
  logic [VALUE_WIDTH-1:0] value_r;

  // walk unit
  logic              first;
  logic [CNT_W-1:0]  idx;
  logic [LINK_W-1:0] tgt;
  logic [LINK_W-1:0] prev;
  logic [LINK_W-1:0] new_slot;
  logic              cmp_v;
  logic [CNT_W-1:0]  cmp_idx;

  // pending result
  logic [VALUE_WIDTH-1:0] res_rd;
  logic [POS_W-1:0]       res_fp;
  status_t                res_st;

  // output register
  logic                   out_valid;
  logic [VALUE_WIDTH-1:0] out_rd;
  logic [POS_W-1:0]       out_fp;
  logic [ST_W-1:0]        out_st;
  logic [CNT_W-1:0]       out_count;

  // RAM ports
  logic                   link_we;
  logic [ADDR_W-1:0]      link_waddr;
  logic [LINK_W-1:0]      link_wdata;
  logic [ADDR_W-1:0]      link_raddr;
  logic [LINK_W-1:0]      link_rdata;
  logic                   elem_we;
  logic [ADDR_W-1:0]      elem_waddr;
  logic [VALUE_WIDTH-1:0] elem_wdata;
  logic [ADDR_W-1:0]      elem_raddr;
  logic [VALUE_WIDTH-1:0] elem_rdata;

  logic [LINK_W-1:0] cur_c;
  logic [PW-1:0]     pos_w;
  logic [PW-1:0]     cnt_w;
  logic [CNT_W-1:0]  ins_pos;
  logic              walk_hit;
  logic              match;
  logic              out_free;

  alle_ram #(.WIDTH(LINK_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  alle_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_waddr),
    .wdata (elem_wdata),
    .raddr (elem_raddr),
    .rdata (elem_rdata)
  );

  assign req.ready          = (state == S_IDLE);
  assign rsp.valid          = out_valid;
  assign rsp.read_value     = out_rd;
  assign rsp.found_position = out_fp;
  assign rsp.status         = out_st;
  assign rsp.item_count     = out_count;

  // first step of a walk starts from head, later steps follow the chain
  assign cur_c    = first ? head : link_rdata;
  assign pos_w    = PW'(pos_raw);
  assign cnt_w    = PW'(count);
  assign ins_pos  = (op_r == OP_APPEND) ? count : pos_w[CNT_W-1:0];
  assign walk_hit = (idx == pos_r);
  assign match    = cmp_v && (elem_rdata == value_r);
  assign out_free = !out_valid || rsp.ready;

  always_comb begin
    link_raddr = tgt[ADDR_W-1:0];
    elem_raddr = tgt[ADDR_W-1:0];
    if (state == S_DECODE) begin
      link_raddr = free_head[ADDR_W-1:0];
    end
    if (state == S_WALK || state == S_SCAN) begin
      link_raddr = cur_c[ADDR_W-1:0];
      elem_raddr = cur_c[ADDR_W-1:0];
    end

    link_we    = 1'b0;
    link_waddr = tgt[ADDR_W-1:0];
    link_wdata = free_head;
    elem_we    = 1'b0;
    elem_waddr = new_slot[ADDR_W-1:0];
    elem_wdata = value_r;
    case (state)
      S_ACCESS: begin
        if (op_r == OP_OVERWRITE) begin
          elem_we    = 1'b1;
          elem_waddr = tgt[ADDR_W-1:0];
        end
        // unlink the removed slot from its predecessor
        if (op_r == OP_REMOVE && pos_r != '0) begin
          link_we    = 1'b1;
          link_waddr = prev[ADDR_W-1:0];
          link_wdata = link_rdata;
        end
      end
      S_FREE: begin
        link_we = 1'b1;
      end
      S_LINK: begin
        link_we    = 1'b1;
        link_waddr = new_slot[ADDR_W-1:0];
        link_wdata = tgt;
        elem_we    = 1'b1;
      end
      S_LINK2: begin
        link_we    = 1'b1;
        link_waddr = prev[ADDR_W-1:0];
        link_wdata = new_slot;
      end
      default: begin
      end
    endcase
  end

  // sequencer and list bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NULL_LINK;
      tail      <= NULL_LINK;
      free_head <= NULL_LINK;
      fresh     <= '0;
      count     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r    <= req.op;
            pos_raw <= req.position;
            value_r <= req.value;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          first  <= 1'b1;
          idx    <= '0;
          cmp_v  <= 1'b0;
          res_rd <= '0;
          res_fp <= '0;
          res_st <= ST_OK;
          case (op_r)
            OP_APPEND, OP_INSERT: begin
              if (op_r == OP_INSERT && pos_w > cnt_w) begin
                res_st <= ST_RANGE;
                state  <= S_DONE;
              end else if (count == CAP_CNT) begin
                res_st <= ST_FULL;
                state  <= S_DONE;
              end else begin
                pos_r <= ins_pos;
                if (free_head != NULL_LINK) begin
                  // recycled slot: fetch its successor on the free chain
                  new_slot <= free_head;
                  state    <= S_POP;
                end else begin
                  new_slot <= fresh;
                  fresh    <= fresh + LINK_W'(1);
                  if (ins_pos == count) begin
                    prev  <= tail;
                    tgt   <= NULL_LINK;
                    state <= S_LINK;
                  end else begin
                    state <= S_WALK;
                  end
                end
              end
            end
            OP_READ, OP_OVERWRITE, OP_REMOVE: begin
              if (pos_w >= cnt_w) begin
                res_st <= ST_RANGE;
                state  <= S_DONE;
              end else begin
                pos_r <= pos_w[CNT_W-1:0];
                state <= S_WALK;
              end
            end
            OP_SEARCH: begin
              res_st <= ST_MISS;
              state  <= S_SCAN;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_POP: begin
          free_head <= link_rdata;
          if (pos_r == count) begin
            prev  <= tail;
            tgt   <= NULL_LINK;
            state <= S_LINK;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (walk_hit) begin
            tgt   <= cur_c;
            state <= (op_r == OP_APPEND || op_r == OP_INSERT) ? S_LINK : S_ACCESS;
          end else begin
            prev  <= cur_c;
            idx   <= idx + CNT_W'(1);
            first <= 1'b0;
          end
        end
        S_SCAN: begin
          // compare checks the read issued in the previous cycle
          if (match) begin
            res_st <= ST_OK;
            res_fp <= POS_W'(cmp_idx);
            state  <= S_DONE;
          end else if (idx == count) begin
            state <= S_DONE;
          end else begin
            cmp_v   <= 1'b1;
            cmp_idx <= idx;
            idx     <= idx + CNT_W'(1);
            first   <= 1'b0;
          end
        end
        S_ACCESS: begin
          res_rd <= elem_rdata;
          if (op_r == OP_REMOVE) begin
            if (pos_r == '0) begin
              head <= link_rdata;
            end
            if (tgt == tail) begin
              tail <= (pos_r == '0) ? NULL_LINK : prev;
            end
            state <= S_FREE;
          end else begin
            state <= S_DONE;
          end
        end
        S_FREE: begin
          free_head <= tgt;
          count     <= count - CNT_W'(1);
          state     <= S_DONE;
        end
        S_LINK: begin
          if (pos_r == '0) begin
            head <= new_slot;
          end
          if (pos_r == count) begin
            tail <= new_slot;
          end
          if (pos_r != '0) begin
            state <= S_LINK2;
          end else begin
            count <= count + CNT_W'(1);
            state <= S_DONE;
          end
        end
        S_LINK2: begin
          count <= count + CNT_W'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register frees
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_rd    <= res_rd;
      out_fp    <= res_fp;
      out_st    <= res_st;
      out_count <= count;
    end
  end

endmodule

`default_nettype wire

@@ rtl/alle_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module alle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/alle_checker.sv @@
// Port-level checks for array_linked_list_engine, attached by bind.
// Depends on alle_pkg for status codes.
`default_nettype none

module alle_checker #(
  parameter int CAPACITY    = 256,
  parameter int VALUE_WIDTH = 32
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [VALUE_WIDTH-1:0]          read_value,
  input logic [alle_pkg::POS_W-1:0]      found_position,
  input logic [alle_pkg::ST_W-1:0]       status,
  input logic [$clog2(CAPACITY+1)-1:0]   item_count
);

  import alle_pkg::*;

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_value) && $stable(status)
      && $stable(found_position) && $stable(item_count))
    else $error("response changed while stalled");

  // one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> item_count == CAPACITY)
    else $error("full status below capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> read_value == '0 && found_position == '0)
    else $error("failed request carries data");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind array_linked_list_engine alle_checker #(
  .CAPACITY    (CAPACITY),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_alle_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .read_value     (rsp.read_value),
  .found_position (rsp.found_position),
  .status         (rsp.status),
  .item_count     (rsp.item_count)
);

`default_nettype wire

@@ bench/array_linked_list_engine_tb.sv @@
// Self-checking testbench for array_linked_list_engine: directed and random list traffic.
// Depends on alle_pkg, alle_if (alle_req_if, alle_rsp_if) and the engine RTL.
`default_nettype none

module array_linked_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alle_pkg::*;

  localparam int CAPACITY       = 256;
  localparam int VALUE_WIDTH    = 32;
  localparam int COUNT_WIDTH    = 9;
  localparam int RANDOM_ITEMS   = 800;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 300;

  // op codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef logic signed [VALUE_WIDTH-1:0] elem_t;

  typedef struct {
    elem_t                  read_value;
    logic [POS_W-1:0]       found_position;
    status_t                status;
    logic [COUNT_WIDTH-1:0] item_count;
  } list_result_t;

  // Shadow list kept in a queue: position i of the chain is entry i here.
  class list_tracker;
    elem_t        elems[$];
    list_result_t pending_results[$];
    int           errors;

    function void apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, elem_t val);
      list_result_t r;
      int           n;
      int           at;
      r.read_value     = '0;
      r.found_position = '0;
      r.status         = ST_OK;
      n = elems.size();
      case (op)
        OP_APPEND, OP_INSERT: begin
          at = (op == OP_APPEND) ? n : int'(pos);
          if (at > n) r.status = ST_RANGE;
          else if (n >= CAPACITY) r.status = ST_FULL;
          else elems.insert(at, val);
        end
        OP_READ, OP_OVERWRITE: begin
          if (int'(pos) >= n) r.status = ST_RANGE;
          else begin
            r.read_value = elems[pos];
            if (op == OP_OVERWRITE) elems[pos] = val;
          end
        end
        OP_REMOVE: begin
          if (int'(pos) >= n) r.status = ST_RANGE;
          else begin
            r.read_value = elems[pos];
            elems.delete(pos);
          end
        end
        OP_SEARCH: begin
          r.status = ST_MISS;
          for (int i = 0; i < n; i++) begin
            if (elems[i] == val) begin
              r.found_position = POS_W'(i);
              r.status         = ST_OK;
              break;
            end
          end
        end
        default: ;
      endcase
      r.item_count = COUNT_WIDTH'(elems.size());
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(elem_t rd, logic [POS_W-1:0] fp, logic [ST_W-1:0] st,
                                 logic [COUNT_WIDTH-1:0] cnt);
      list_result_t r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual value %0h status %0d",
                 $time, rd, st);
        errors++;
      end else begin
        r = pending_results.pop_front();
        compare_field("read_value", r.read_value, rd);
        compare_field("found_position", r.found_position, fp);
        compare_field("status", r.status, st);
        compare_field("item_count", r.item_count, cnt);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic steady;
  int   idle_cycles;

  alle_req_if #(.VALUE_WIDTH(VALUE_WIDTH)) req_ch ();
  alle_rsp_if #(.VALUE_WIDTH(VALUE_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) rsp_ch ();

  list_tracker tracker = new;

  array_linked_list_engine #(
    .CAPACITY   (CAPACITY),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check responses before noting a request taken at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready)
        tracker.check_response(rsp_ch.read_value, rsp_ch.found_position, rsp_ch.status,
                               rsp_ch.item_count);
      if (req_ch.valid && req_ch.ready)
        tracker.apply_request(req_ch.op, req_ch.position, req_ch.value);
      if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[array_linked_list_engine] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Response side: stall a random number of cycles before each transaction, except in steady mode.
  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input elem_t val);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= op;
    req_ch.position <= pos;
    req_ch.value    <= val;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid so the last transaction is not taken again while waiting.
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic elem_t pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return elem_t'(32'h8000_0000);
    if (r < 6) return elem_t'(32'h7fff_ffff);
    if (r < 8) return elem_t'(-1);
    if (r < 30) return elem_t'($urandom_range(0, 15));
    return elem_t'($urandom);
  endfunction

  // Mostly positions inside the list, sometimes anywhere in the field.
  function automatic logic [POS_W-1:0] pick_position(int limit);
    int p;
    if ($urandom_range(0, 99) < 15 || limit <= 0) p = $urandom_range(0, 255);
    else p = $urandom_range(0, limit - 1);
    if (p > 255) p = 255;
    return POS_W'(p);
  endfunction

  function automatic elem_t pick_search_value();
    int n;
    n = tracker.elems.size();
    if (n > 0 && $urandom_range(0, 99) < 60) return tracker.elems[$urandom_range(0, n - 1)];
    return pick_value();
  endfunction

  task automatic send_random(input bit growing);
    int n;
    int r;
    n = tracker.elems.size();
    r = $urandom_range(0, 99);
    if (!growing) r = (r < 10) ? r * 4 : ((r < 15) ? 70 + r : r);
    if (growing) begin
      if (r < 45) send_request(OP_APPEND, POS_W'($urandom), pick_value());
      else if (r < 80) send_request(OP_INSERT, pick_position(n + 1), pick_value());
      else if (r < 85) send_request(OP_REMOVE, pick_position(n), pick_value());
      else if (r < 90) send_request(OP_READ, pick_position(n), pick_value());
      else if (r < 94) send_request(OP_OVERWRITE, pick_position(n), pick_value());
      else if (r < 98) send_request(OP_SEARCH, pick_position(n), pick_search_value());
      else send_request(r[0] ? OP_SPARE_7 : OP_SPARE_6, POS_W'($urandom), pick_value());
    end else begin
      if (r < 40) send_request(OP_APPEND, POS_W'($urandom), pick_value());
      else if (r < 84) send_request(OP_REMOVE, pick_position(n), pick_value());
      else if (r < 87) send_request(OP_INSERT, pick_position(n + 1), pick_value());
      else if (r < 91) send_request(OP_READ, pick_position(n), pick_value());
      else if (r < 94) send_request(OP_OVERWRITE, pick_position(n), pick_value());
      else if (r < 98) send_request(OP_SEARCH, pick_position(n), pick_search_value());
      else send_request(r[0] ? OP_SPARE_7 : OP_SPARE_6, POS_W'($urandom), pick_value());
    end
  endtask

  initial begin
    bit growing;
    int full_items;
    rst             = 1'b1;
    steady          = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.op       = OP_APPEND;
    req_ch.position = '0;
    req_ch.value    = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty list: every access is out of range, search misses
    send_request(OP_READ, 8'd0, 32'sd0);
    send_request(OP_REMOVE, 8'd0, 32'sd0);
    send_request(OP_SEARCH, 8'd0, 32'sd0);
    send_request(OP_INSERT, 8'd1, 32'sd9);
    send_request(OP_SPARE_6, 8'd255, 32'sd0);
    // build a short list through the head, tail and middle insert paths
    send_request(OP_INSERT, 8'd0, 32'sd5);
    send_request(OP_APPEND, 8'd0, elem_t'(32'h7fff_ffff));
    send_request(OP_APPEND, 8'd0, elem_t'(32'h8000_0000));
    send_request(OP_INSERT, 8'd3, elem_t'(-1));
    send_request(OP_INSERT, 8'd1, 32'sd0);
    send_request(OP_READ, 8'd4, 32'sd0);
    send_request(OP_READ, 8'd5, 32'sd0);
    send_request(OP_READ, 8'd255, 32'sd0);
    send_request(OP_OVERWRITE, 8'd2, elem_t'(32'h5555_5555));
    send_request(OP_SEARCH, 8'd0, elem_t'(-1));
    send_request(OP_SEARCH, 8'd0, elem_t'(32'h1234_5678));
    // remove tail, head, then middle
    send_request(OP_REMOVE, 8'd4, 32'sd0);
    send_request(OP_REMOVE, 8'd0, 32'sd0);
    send_request(OP_REMOVE, 8'd1, 32'sd0);
    send_request(OP_SPARE_7, 8'd0, elem_t'(-1));
    send_request(OP_OVERWRITE, 8'd200, 32'sd1);
    send_request(OP_APPEND, 8'd0, elem_t'(32'haaaa_aaaa));
    send_request(OP_INSERT, 8'd1, 32'sd7);
    send_request(OP_SEARCH, 8'd0, elem_t'(32'haaaa_aaaa));

    // alternate fill and drain phases; linger at full to hit full status
    growing    = 1'b1;
    full_items = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i == 200 || i == 600) wait_for_drain();
      if (growing && tracker.elems.size() == CAPACITY) full_items++;
      if (growing && full_items >= 12) begin
        growing    = 1'b0;
        full_items = 0;
      end else if (!growing && tracker.elems.size() == 0) begin
        growing = 1'b1;
      end
      send_random(growing);
    end
    req_ch.valid <= 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (tracker.errors == 0) begin
      $display("[array_linked_list_engine] OK");
    end else begin
      $display("[array_linked_list_engine] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
